FILE: src/dbcf_pkg.sv
// ----------------------------------------------------------------------------
// dbcf_pkg
// shared types and constants of the dark/bright channel filter
// ----------------------------------------------------------------------------
package dbcf_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam int ROW_W    = 13;   // row counter runs into the bottom border rows
    localparam int VAL_W    = 8;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_READ  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    function automatic logic [VAL_W-1:0] pick(input logic mode_max,
                                              input logic [VAL_W-1:0] acc,
                                              input logic [VAL_W-1:0] v);
        if (mode_max) begin
            return (v > acc) ? v : acc;
        end
        return (v < acc) ? v : acc;
    endfunction

endpackage

FILE: src/dark_bright_channel_filter.sv
// ----------------------------------------------------------------------------
// dark_bright_channel_filter
// window min/max over BGR channels with replicated borders, rows kept in a
// ring of line stores in one synchronous memory
// ----------------------------------------------------------------------------
// timing: an item is written to the line store at its accept edge; its results are
//   swept one at a time over the clipped window (at most (2*radius+1)^2 reads each)
// throughput: sequential; no new item is taken while results of the last are pending,
//   and results wait while the output is stalled (one memory read port)
// reset: synchronous active low; counters at zero, registers to defaults,
//   line store not cleared (no entry is read before it is written)
module dark_bright_channel_filter #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_data,
    // pixel request in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_bgr[23:0]
    input  logic        s_axis_tuser,   // flush
    // result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // filtered_value[7:0]
    output logic        m_axis_tlast,   // end_of_row
    output logic        m_axis_tuser    // end_of_frame
);

    localparam int RING  = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(RING);
    localparam int NW    = $clog2(RING + 1);
    localparam int WW0   = $clog2(MAX_WIDTH + 1);
    localparam int WW    = (WW0 > 12) ? WW0 : 12;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int YW    = dbcf_pkg::ROW_W;
    localparam int VW    = dbcf_pkg::VAL_W;

    // configuration registers
    logic          r_mode;
    logic [2:0]    r_radius;
    logic [11:0]   r_width;
    logic [11:0]   r_height;

    // counters
    logic [WW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [SW-1:0] r_slot;

    // job registers
    dbcf_pkg::t_state r_state;
    logic [WW-1:0] r_ox, r_hi, r_c0, r_c1, r_wx;
    logic [SW-1:0] r_slot0, r_ws;
    logic [NW-1:0] r_nrows, r_rows_left;
    logic          r_oy_last;
    logic          r_rd_vld;
    logic [VW-1:0] r_acc, r_rdata;

    logic [VW-1:0] mem [DEPTH];

    // effective configuration
    logic [WW-1:0] w_eff;
    logic [YW-1:0] h_eff, rr;
    always_comb begin
        if (r_width == 12'd0) begin
            w_eff = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height == 12'd0) ? YW'(1) : YW'(r_height);
        rr    = (int'(r_radius) > MAX_RADIUS) ? YW'(MAX_RADIUS) : YW'(r_radius);
    end

    logic [WW-1:0] rw;
    assign rw = WW'(rr);

    // accept side decode
    logic          acc_in, is_img, do_wr, has_out, x_last;
    logic [VW-1:0] red_v;
    logic [WW-1:0] lo, hi;
    logic [YW-1:0] r0, r1, kk;
    logic [SW-1:0] slot0;
    logic [AW-1:0] wr_addr, rd_addr;

    assign s_axis_tready = (r_state == dbcf_pkg::S_IDLE);
    assign acc_in        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        is_img  = (r_y < h_eff);
        do_wr   = is_img && !s_axis_tuser;
        x_last  = (r_x == w_eff - WW'(1));
        has_out = (r_y >= rr) && (x_last || (r_x >= rw));
        red_v   = dbcf_pkg::pick(r_mode, s_axis_tdata[7:0], s_axis_tdata[15:8]);
        red_v   = dbcf_pkg::pick(r_mode, red_v, s_axis_tdata[23:16]);
        if (x_last) begin
            lo = (r_x >= rw) ? r_x - rw : '0;
            hi = w_eff - WW'(1);
        end else begin
            lo = r_x - rw;
            hi = r_x - rw;
        end
        r0 = (r_y >= (rr << 1)) ? r_y - (rr << 1) : '0;
        r1 = is_img ? r_y : h_eff - YW'(1);
        kk = r_y - r0;
        if (r_slot >= SW'(kk)) begin
            slot0 = r_slot - SW'(kk);
        end else begin
            slot0 = SW'(YW'(r_slot) + YW'(RING) - kk);
        end
        wr_addr = AW'(r_slot) * AW'(MAX_WIDTH) + AW'(r_x);
        rd_addr = AW'(r_ws) * AW'(MAX_WIDTH) + AW'(r_wx);
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (acc_in && do_wr) begin
            mem[wr_addr] <= red_v;
        end
        r_rdata <= mem[rd_addr];
    end

    // configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_radius <= 3'd1;
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_x      <= '0;
            r_y      <= '0;
            r_slot   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dbcf_pkg::REG_MODE:   r_mode   <= i_cfg_data[0];
                dbcf_pkg::REG_RADIUS: r_radius <= i_cfg_data[2:0];
                dbcf_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                dbcf_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
            r_x    <= '0;
            r_y    <= '0;
            r_slot <= '0;
        end else if (acc_in && !(is_img && s_axis_tuser)) begin
            if (x_last) begin
                r_x <= '0;
                if (r_y + YW'(1) >= h_eff + rr) begin
                    r_y    <= '0;
                    r_slot <= '0;
                end else begin
                    r_y    <= r_y + YW'(1);
                    r_slot <= (int'(r_slot) == RING - 1) ? '0 : r_slot + SW'(1);
                end
            end else begin
                r_x <= r_x + WW'(1);
            end
        end
    end

    // window sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dbcf_pkg::S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= 1'b0;
            case (r_state)
                dbcf_pkg::S_IDLE: begin
                    if (acc_in && !(is_img && s_axis_tuser) && has_out) begin
                        r_ox      <= lo;
                        r_hi      <= hi;
                        r_slot0   <= slot0;
                        r_nrows   <= NW'(r1 - r0 + YW'(1));
                        r_oy_last <= (r_y - rr == h_eff - YW'(1));
                        r_state   <= dbcf_pkg::S_SETUP;
                    end
                end
                dbcf_pkg::S_SETUP: begin
                    r_c0        <= (r_ox >= rw) ? r_ox - rw : '0;
                    r_c1        <= (r_ox + rw > w_eff - WW'(1)) ? w_eff - WW'(1) : r_ox + rw;
                    r_wx        <= (r_ox >= rw) ? r_ox - rw : '0;
                    r_ws        <= r_slot0;
                    r_rows_left <= r_nrows;
                    r_acc       <= r_mode ? '0 : '1;
                    r_state     <= dbcf_pkg::S_READ;
                end
                dbcf_pkg::S_READ: begin
                    // issue one read a cycle; its data folds into the accumulator in the next cycle
                    if (r_rows_left != '0) begin
                        r_rd_vld <= 1'b1;
                        if (r_wx == r_c1) begin
                            r_wx        <= r_c0;
                            r_ws        <= (int'(r_ws) == RING - 1) ? '0 : r_ws + SW'(1);
                            r_rows_left <= r_rows_left - NW'(1);
                        end else begin
                            r_wx <= r_wx + WW'(1);
                        end
                    end else if (!r_rd_vld) begin
                        r_state <= dbcf_pkg::S_OUT;
                    end
                end
                dbcf_pkg::S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_ox == r_hi) begin
                            r_state <= dbcf_pkg::S_IDLE;
                        end else begin
                            r_ox    <= r_ox + WW'(1);
                            r_state <= dbcf_pkg::S_SETUP;
                        end
                    end
                end
                default: r_state <= dbcf_pkg::S_IDLE;
            endcase
            if (r_rd_vld) begin
                r_acc <= dbcf_pkg::pick(r_mode, r_acc, r_rdata);
            end
        end
    end

    assign m_axis_tvalid = (r_state == dbcf_pkg::S_OUT);
    assign m_axis_tdata  = r_acc;
    assign m_axis_tlast  = (r_ox == w_eff - WW'(1));
    assign m_axis_tuser  = m_axis_tlast && r_oy_last;

    // checks
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input taken while result pending");
    a_out_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_rows_left == '0 && !r_rd_vld))
        else $error("result shown before window sweep done");
    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbcf_pkg::S_SETUP) |-> (r_nrows != '0 && int'(r_nrows) <= RING))
        else $error("window row count out of range");

endmodule

FILE: bench/dbcf_checker.sv
// ----------------------------------------------------------------------------
// dbcf_checker
// watches the pixel and result streams of the dark/bright channel filter,
// predicts every window value and compares results in order
// ----------------------------------------------------------------------------
module dbcf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_data,
    input  logic        i_px_valid,
    input  logic        i_px_ready,
    input  logic [23:0] i_px_data,
    input  logic        i_px_flush,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [7:0]  i_res_data,
    input  logic        i_res_eor,
    input  logic        i_res_eof,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 15;
    localparam int MAXW = 2048;

    typedef struct packed {
        logic [7:0] value;
        logic       eor;
        logic       eof;
    } t_result;

    logic [7:0]  rows_seen [RING][MAXW];
    logic        cfg_max;
    logic [2:0]  cfg_radius;
    logic [11:0] cfg_width;
    logic [11:0] cfg_height;
    int          col;
    int          row;
    t_result     expected_q[$];
    int          errors;
    int          results;
    int          pending_cnt = 0;

    assign o_errors  = errors;
    assign o_pending = pending_cnt;
    assign o_results = results;

    function automatic logic [7:0] reduce(logic [7:0] a, logic [7:0] b);
        if (cfg_max) begin
            return (b > a) ? b : a;
        end
        return (b < a) ? b : a;
    endfunction

    function automatic logic [7:0] window_extreme(int oy, int ox, int w, int h, int r);
        logic [7:0] acc;
        int y0, y1, x0, x1;
        acc = cfg_max ? 8'd0 : 8'd255;
        y0 = (oy >= r) ? oy - r : 0;
        y1 = (oy + r > h - 1) ? h - 1 : oy + r;
        x0 = (ox >= r) ? ox - r : 0;
        x1 = (ox + r > w - 1) ? w - 1 : ox + r;
        for (int y = y0; y <= y1; y++) begin
            for (int x = x0; x <= x1; x++) begin
                acc = reduce(acc, rows_seen[y % RING][x]);
            end
        end
        return acc;
    endfunction

    // store one accepted request, queue its predicted results and advance the raster position
    task automatic predict_pixel(logic [23:0] px, logic flush);
        int w, h, r, lo, hi;
        logic [7:0] v;
        t_result res;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        r = cfg_radius;
        if (row < h) begin
            if (flush) begin
                return;
            end
            v = reduce(reduce(px[7:0], px[15:8]), px[23:16]);
            rows_seen[row % RING][col] = v;
        end
        if (row >= r) begin
            lo = -1;
            if (col == w - 1) begin
                lo = (col >= r) ? col - r : 0;
                hi = w - 1;
            end else if (col >= r) begin
                lo = col - r;
                hi = col - r;
            end
            if (lo >= 0) begin
                for (int ox = lo; ox <= hi; ox++) begin
                    res.value = window_extreme(row - r, ox, w, h, r);
                    res.eor   = (ox == w - 1);
                    res.eof   = res.eor && (row - r == h - 1);
                    expected_q.push_back(res);
                end
            end
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h + r) begin
                row = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            cfg_max    <= 1'b0;
            cfg_radius <= 3'd1;
            cfg_width  <= 12'd640;
            cfg_height <= 12'd480;
            col = 0;
            row = 0;
            errors = 0;
            results = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    dbcf_pkg::REG_MODE:   cfg_max    <= i_cfg_data[0];
                    dbcf_pkg::REG_RADIUS: cfg_radius <= i_cfg_data[2:0];
                    dbcf_pkg::REG_WIDTH:  cfg_width  <= i_cfg_data;
                    dbcf_pkg::REG_HEIGHT: cfg_height <= i_cfg_data;
                    default: ;
                endcase
                col = 0;
                row = 0;
            end
            if (i_px_valid && i_px_ready) begin
                predict_pixel(i_px_data, i_px_flush);
            end
            if (i_res_valid && i_res_ready) begin
                results++;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result value=%0d eor=%0b eof=%0b",
                             $time, i_res_data, i_res_eor, i_res_eof);
                end else begin
                    exp_res = expected_q.pop_front();
                    if (exp_res.value !== i_res_data || exp_res.eor !== i_res_eor ||
                        exp_res.eof !== i_res_eof) begin
                        errors++;
                        $display("%0t: mismatch expected value=%0d eor=%0b eof=%0b,",
                                 $time, exp_res.value, exp_res.eor, exp_res.eof,
                                 " got value=%0d eor=%0b eof=%0b",
                                 i_res_data, i_res_eor, i_res_eof);
                    end
                end
            end
        end
        pending_cnt = expected_q.size();
    end

endmodule

FILE: bench/tb_dark_bright_channel_filter.sv
// ----------------------------------------------------------------------------
// tb_dark_bright_channel_filter
// drives small frames in both modes and several window sizes, with random
// gaps and stalls, and lets the checker compare every result
// ----------------------------------------------------------------------------
module tb_dark_bright_channel_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = dbcf_pkg::REG_MODE;
    logic [11:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    int  errors, pending, results;
    int  requests_sent = 0;
    int  frames_sent = 0;
    int  idle_cycles = 0;
    bit  hold_sink = 1'b0;
    bit  long_hold = 1'b0;

    always #5 i_clk = ~i_clk;

    dark_bright_channel_filter dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
    );

    dbcf_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .i_px_valid(s_axis_tvalid), .i_px_ready(s_axis_tready),
        .i_px_data(s_axis_tdata), .i_px_flush(s_axis_tuser),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_eor(m_axis_tlast), .i_res_eof(m_axis_tuser),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // result sink: random stall per result, one long hold when asked
    always begin
        int gap;
        @(posedge i_clk);
        if (long_hold) begin
            m_axis_tready <= 1'b0;
            repeat (400) @(posedge i_clk);
            long_hold = 1'b0;
        end
        gap = hold_sink ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            m_axis_tready <= 1'b0;
            repeat (gap - 1) @(posedge i_clk);
            @(posedge i_clk);
        end
        m_axis_tready <= 1'b1;
        do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        m_axis_tready <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [11:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(logic [23:0] px, logic flush, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= flush;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_pixel(int style);
        case (style)
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255))};
        endcase
    endfunction

    // one frame: pixels with stray flushes while in the image, then the flush rows
    task automatic run_frame(bit mode_max, int radius, int w, int h, bit fast,
                             int style, bit noise);
        int eff_w, eff_h, eff_r;
        write_reg(dbcf_pkg::REG_MODE, 12'(mode_max));
        write_reg(dbcf_pkg::REG_RADIUS, 12'(radius));
        write_reg(dbcf_pkg::REG_WIDTH, 12'(w));
        write_reg(dbcf_pkg::REG_HEIGHT, 12'(h));
        eff_w = (w == 0) ? 1 : w;
        eff_h = (h == 0) ? 1 : h;
        eff_r = radius;
        for (int i = 0; i < eff_w * eff_h; i++) begin
            if (noise && $urandom_range(0, 7) == 0) begin
                send_request(pick_pixel(2), 1'b1, fast);
            end
            send_request(pick_pixel(style), 1'b0, fast);
        end
        for (int i = 0; i < eff_r * eff_w; i++) begin
            // a pixel here counts as a flush
            send_request(pick_pixel(2), (noise && $urandom_range(0, 3) == 0) ? 1'b0 : 1'b1,
                         fast);
        end
        frames_sent++;
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of values, tiny and degenerate sizes, radius 0 and max
        run_frame(1'b0, 1, 3, 3, 1'b0, 0, 1'b1);
        run_frame(1'b1, 0, 1, 1, 1'b0, 1, 1'b0);
        run_frame(1'b0, 7, 2, 2, 1'b0, 2, 1'b0);
        run_frame(1'b1, 2, 0, 0, 1'b0, 2, 1'b1);
        send_request(24'hFFFFFF, 1'b0, 1'b0);
        send_request(24'h0F0F0F, 1'b0, 1'b0);
        drain();

        // receiver holds off while the sender keeps offering
        long_hold = 1'b1;
        run_frame(1'b1, 1, 5, 3, 1'b1, 2, 1'b0);

        while (requests_sent < 255) begin
            hold_sink = ($urandom_range(0, 3) == 0);
            run_frame(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                      $urandom_range(1, 6), $urandom_range(1, 5),
                      $urandom_range(0, 3) == 0, $urandom_range(0, 5),
                      $urandom_range(0, 2) == 0);
        end
        hold_sink = 1'b0;
        run_frame(1'b0, 7, 9, 2, 1'b0, 2, 1'b0);

        $display("covered %0d frames, %0d requests, %0d results in both modes",
                 frames_sent, requests_sent, results);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: dark_bright_channel_filter.f
src/dbcf_pkg.sv
src/dark_bright_channel_filter.sv
bench/dbcf_checker.sv
bench/tb_dark_bright_channel_filter.sv
